/* hw/rtl/imad_pkg.sv */
package imad_pkg;

  localparam int IdxMax = 88;

  localparam int CodeW   = 4;
  localparam int MagW    = 3;
  localparam int IdxW    = 7;
  localparam int StepW   = 15;
  localparam int PredW   = 16;
  localparam int SampleW = 8;
  localparam int InDataW  = 8;
  localparam int OutDataW = 8;

  // difference needs 17 bits, the sum one sign bit and one guard bit more
  localparam int DiffW = StepW + 2;
  localparam int SumW  = DiffW + 2;

  localparam logic signed [SumW-1:0] PredMin = -(SumW'(32768));
  localparam logic signed [SumW-1:0] PredMax = SumW'(32767);

  typedef logic [CodeW-1:0]          code_t;
  typedef logic [IdxW-1:0]           idx_t;
  typedef logic [StepW-1:0]          step_t;
  typedef logic signed [PredW-1:0]   pred_t;
  typedef logic [SampleW-1:0]        sample_t;

  localparam step_t StepTab [0:IdxMax] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
    15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
    15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
    15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
    15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
    15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
    15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
    15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
    15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
    15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
    15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
  };

  function automatic step_t step_lookup(input idx_t idx);
    step_t s;
    if (idx > IdxW'(IdxMax)) begin
      s = StepTab[IdxMax];
    end else begin
      s = StepTab[idx];
    end
    return s;
  endfunction

  function automatic logic signed [4:0] idx_adjust(input logic [MagW-1:0] mag);
    logic signed [4:0] a;
    case (mag)
      3'd4:    a = 5'sd2;
      3'd5:    a = 5'sd4;
      3'd6:    a = 5'sd7;
      3'd7:    a = 5'sd12;
      default: a = -5'sd1;
    endcase
    return a;
  endfunction

endpackage

/* hw/rtl/imad_datapath.sv */
module imad_datapath (
  input  imad_pkg::code_t   code,
  input  imad_pkg::pred_t   pred,
  input  imad_pkg::idx_t    idx,
  output imad_pkg::pred_t   pred_nxt,
  output imad_pkg::idx_t    idx_nxt,
  output imad_pkg::sample_t sample
);
  import imad_pkg::*;

  logic [MagW-1:0]         mag;
  step_t                   step;
  logic [DiffW-1:0]        diff;
  logic signed [SumW-1:0]  sum;
  logic signed [7:0]       ni;

  assign mag  = code[MagW-1:0];
  assign step = step_lookup(idx);

  always_comb begin
    diff = DiffW'(step >> 3);
    if (mag[0]) diff = diff + DiffW'(step >> 2);
    if (mag[1]) diff = diff + DiffW'(step >> 1);
    if (mag[2]) diff = diff + DiffW'(step);
    if (mag == 3'd7) diff = diff + DiffW'(step >> 1);
  end

  // sign bit of the code negates the difference
  always_comb begin
    if (code[CodeW-1]) begin
      sum = SumW'(pred) - $signed({2'b00, diff});
    end else begin
      sum = SumW'(pred) + $signed({2'b00, diff});
    end
    if (sum < PredMin) begin
      pred_nxt = PredMin[PredW-1:0];
    end else if (sum > PredMax) begin
      pred_nxt = PredMax[PredW-1:0];
    end else begin
      pred_nxt = sum[PredW-1:0];
    end
  end

  always_comb begin
    ni = $signed({1'b0, idx}) + 8'(idx_adjust(mag));
    if (ni < 0) begin
      idx_nxt = '0;
    end else if (ni > 8'sd88) begin
      idx_nxt = IdxW'(IdxMax);
    end else begin
      idx_nxt = ni[IdxW-1:0];
    end
  end

  // (p + 32768) >> 8 is the high byte with its top bit flipped
  assign sample = {~pred_nxt[PredW-1], pred_nxt[PredW-2:PredW-SampleW]};

endmodule

/* hw/rtl/ima_style_adpcm_nibble_decoder_unit.sv */
// IMA-style ADPCM nibble decoder.
// Input stream: one 4-bit code per transaction in in_tdata[3:0] (bit 3 sign,
// bits 2..0 magnitude); in_tlast marks the final nibble of a packet. The
// feeder sends the low nibble of each byte first.
// Output stream: one unsigned 8-bit sample per input transaction in
// out_tdata, with out_tlast copied from the matching input.
// Data passes the input register, then the result register; out_tvalid rises
// once the accepted code has moved from the input register into the result
// register. Throughput: one nibble per clock while the receiver does not
// stall; the predictor and step index update in the single combinational
// pass between the two registers, which sets the cycle.
// Reset (rst_n low, synchronous): predictor and step index go to zero and
// both register stages empty. Packet ends do not reset the state.
// When the receiver stalls, a finished sample waits in the output register
// while one more code can still be taken into the input register; after
// that in_tready drops until out_tready returns. No transaction is lost.
module ima_style_adpcm_nibble_decoder_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [imad_pkg::InDataW-1:0]  in_tdata,   // [3:0] code, [7:4] zero
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [imad_pkg::OutDataW-1:0] out_tdata,  // [7:0] sample
  output logic                          out_tlast
);
  import imad_pkg::*;

  logic    in_vld_r;
  code_t   in_code_r;
  logic    in_last_r;
  logic    out_vld_r;
  sample_t out_sample_r;
  logic    out_last_r;
  pred_t   pred_r;
  idx_t    idx_r;

  pred_t   pred_nxt;
  idx_t    idx_nxt;
  sample_t sample_nxt;
  logic    out_free;
  logic    advance;

  imad_datapath u_datapath (
    .code     (in_code_r),
    .pred     (pred_r),
    .idx      (idx_r),
    .pred_nxt (pred_nxt),
    .idx_nxt  (idx_nxt),
    .sample   (sample_nxt)
  );

  assign out_free  = !out_vld_r || out_tready;
  assign advance   = in_vld_r && out_free;
  assign in_tready = !in_vld_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pred_r    <= '0;
      idx_r     <= '0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (out_free) begin
        out_vld_r <= in_vld_r;
      end
      if (advance) begin
        pred_r <= pred_nxt;
        idx_r  <= idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_code_r <= in_tdata[CodeW-1:0];
      in_last_r <= in_tlast;
    end
    if (advance) begin
      out_sample_r <= sample_nxt;
      out_last_r   <= in_last_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_sample_r;
  assign out_tlast  = out_last_r;

endmodule

/* bench/tb_ima_style_adpcm_nibble_decoder_unit.sv */
`timescale 1ns / 1ps

module tb_ima_style_adpcm_nibble_decoder_unit;
  import imad_pkg::*;

  localparam int ClkHalf      = 5;
  localparam int ResetCycles  = 4;
  localparam int HoldCycles   = 300;
  localparam int DrainCycles  = 10;
  localparam int CycleLimit   = 200000;
  localparam int PhaseItems   = 460;
  localparam int MaxPktLen    = 32;
  localparam int SignBit      = CodeW - 1;

  // packet flavors for the random part
  typedef enum int {
    PKT_MIXED,
    PKT_LOUD,
    PKT_QUIET
  } pkt_kind_t;

  typedef struct {
    sample_t sample;
    logic    last;
  } sample_txn_t;

  class adpcm_sample_scoreboard;
    localparam int IdxShift [0:7] = '{-1, -1, -1, -1, 2, 4, 7, 12};

    pred_t       pred;
    idx_t        idx;
    sample_txn_t pending_samples [$];
    int          errors;

    function new();
      pred   = '0;
      idx    = '0;
      errors = 0;
    endfunction

    // decode one accepted nibble and queue the sample it must produce
    function void note_code(code_t code, logic last);
      int          step;
      int          diff;
      int          sum;
      int          next_idx;
      int          mag;
      sample_txn_t txn;
      mag  = int'(code[MagW-1:0]);
      step = int'(StepTab[idx]);
      diff = step >>> 3;
      if (mag[0]) diff += step >>> 2;
      if (mag[1]) diff += step >>> 1;
      if (mag[2]) diff += step;
      if (mag == 7) diff += step >>> 1;
      if (code[SignBit]) diff = -diff;
      sum = int'(pred) + diff;
      if (sum < -32768) sum = -32768;
      if (sum > 32767) sum = 32767;
      pred = pred_t'(sum);
      next_idx = int'(idx) + IdxShift[mag];
      if (next_idx < 0) next_idx = 0;
      if (next_idx > IdxMax) next_idx = IdxMax;
      idx = idx_t'(next_idx);
      txn.sample = sample_t'((sum + 32768) >> 8);
      txn.last   = last;
      pending_samples.push_back(txn);
    endfunction

    function void check_sample(sample_t sample, logic last);
      sample_txn_t exp_txn;
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample transaction: sample %0d last %0b",
                 $time, sample, last);
        errors++;
      end else begin
        exp_txn = pending_samples.pop_front();
        if (sample !== exp_txn.sample) begin
          $display("%0t: sample mismatch: expected %0d actual %0d",
                   $time, exp_txn.sample, sample);
          errors++;
        end
        if (last !== exp_txn.last) begin
          $display("%0t: tlast mismatch: expected %0b actual %0b",
                   $time, exp_txn.last, last);
          errors++;
        end
      end
    endfunction

    function int outstanding();
      return pending_samples.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tlast;

  adpcm_sample_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int cycle_count;

  ima_style_adpcm_nibble_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #ClkHalf clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_ima_style_adpcm_nibble_decoder_unit NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_sample(out_tdata[SampleW-1:0], out_tlast);
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end
      out_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_code(input code_t code, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = InDataW'(code);
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    sb.note_code(code, last);
  endtask

  task automatic send_directed();
    int n;
    n = 0;
    // magnitude zero at index zero checks the lower index clamp
    send_code(code_t'(0), 1'b0);
    send_code(code_t'(8), 1'b0);
    // largest positive codes drive the index to its top and the predictor to +max
    repeat (8) begin
      send_code(code_t'(7), 1'b0);
    end
    // largest negative codes hit the negative rail
    repeat (3) begin
      send_code(code_t'(15), 1'b0);
    end
    for (int c = 1; c < 15; c++) begin
      if (c != 7 && c != 8) begin
        n++;
        send_code(code_t'(c), (n % 4 == 0));
      end
    end
  endtask

  task automatic send_packets(input int item_count);
    int        sent;
    int        len;
    pkt_kind_t kind;
    logic      sign;
    code_t     code;
    sent = 0;
    while (sent < item_count) begin
      len  = $urandom_range(MaxPktLen, 1);
      sign = 1'($urandom_range(1));
      case ($urandom_range(9))
        0, 1:    kind = PKT_LOUD;
        2, 3:    kind = PKT_QUIET;
        default: kind = PKT_MIXED;
      endcase
      for (int i = 0; i < len; i++) begin
        case (kind)
          PKT_LOUD: begin
            // mostly one sign so the predictor rides into saturation
            code = {($urandom_range(7) == 0) ? ~sign : sign,
                    MagW'($urandom_range(7, 4))};
          end
          PKT_QUIET: begin
            code = {logic'($urandom_range(1)), MagW'($urandom_range(3))};
          end
          default: begin
            code = code_t'($urandom_range(15));
          end
        endcase
        send_code(code, (i == len - 1));
      end
      sent += len;
    end
  endtask

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tlast       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    cycle_count    = 0;
    repeat (ResetCycles) @(negedge clk);
    rst_n = 1'b1;

    send_directed();

    // no idling, with one long receiver hold-off to back up the input
    hold_req = 1'b1;
    send_packets(PhaseItems);

    send_idle_pct = 57;
    recv_stall_pct = 0;
    send_packets(PhaseItems);

    send_idle_pct = 0;
    recv_stall_pct = 57;
    send_packets(PhaseItems);

    send_idle_pct = 33;
    recv_stall_pct = 33;
    send_packets(PhaseItems);

    @(negedge clk);
    in_tvalid = 1'b0;
    recv_stall_pct = 0;
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb_ima_style_adpcm_nibble_decoder_unit OK");
    end else begin
      $display("tb_ima_style_adpcm_nibble_decoder_unit NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/imad_pkg.sv
hw/rtl/imad_datapath.sv
hw/rtl/ima_style_adpcm_nibble_decoder_unit.sv
bench/tb_ima_style_adpcm_nibble_decoder_unit.sv
